@@ hw/rtl/i8080_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080_pkg
// Shared constants, types and arithmetic helpers of the 8080 processor core.
// ----------------------------------------------------------------------------
package i8080_pkg;

	localparam int MEM_DEPTH = 65536;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	// Request types.
	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_EXEC = 2'd1;
	localparam logic [1:0] REQ_IRQ  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_WRITE_LOW  = 1'b0;
	localparam logic CFG_WRITE_HIGH = 1'b1;

	localparam logic [16:0] WRITE_LOW_RST  = 17'h02000;
	localparam logic [16:0] WRITE_HIGH_RST = 17'h04000;

	// Bit positions in the internal flag vector.
	localparam int F_CY = 0;
	localparam int F_P  = 1;
	localparam int F_AC = 2;
	localparam int F_Z  = 3;
	localparam int F_S  = 4;

	localparam logic [7:0] OP_HLT  = 8'h76;
	localparam logic [7:0] OP_XTHL = 8'hE3;

	// ALU operation codes, as encoded in bits 5:3 of the opcode.
	localparam logic [2:0] ALU_ADD = 3'd0;
	localparam logic [2:0] ALU_ADC = 3'd1;
	localparam logic [2:0] ALU_SUB = 3'd2;
	localparam logic [2:0] ALU_SBB = 3'd3;
	localparam logic [2:0] ALU_ANA = 3'd4;
	localparam logic [2:0] ALU_XRA = 3'd5;
	localparam logic [2:0] ALU_ORA = 3'd6;
	localparam logic [2:0] ALU_CMP = 3'd7;

	typedef struct packed {
		logic [7:0] res;
		logic       cy;
		logic       ac;
	} alu_out_t;

	function automatic alu_out_t alu_f(input logic [2:0] sel, input logic [7:0] a,
			input logic [7:0] b, input logic cy);
		alu_out_t   o;
		logic       c;
		logic [8:0] s;
		logic [7:0] x;
		c = (sel == ALU_ADC || sel == ALU_SBB) ? cy : 1'b0;
		o = '0;
		s = '0;
		case (sel)
			ALU_ADD, ALU_ADC: begin
				s = {1'b0, a} + {1'b0, b} + {8'd0, c};
				o.res = s[7:0];
				o.cy = s[8];
				x = a ^ b ^ o.res;
				o.ac = x[4];
			end
			ALU_SUB, ALU_SBB, ALU_CMP: begin
				s = {1'b0, b} + {8'd0, c};
				o.cy = ({1'b0, a} < s);
				o.res = a - b - {7'd0, c};
				x = a ^ b ^ o.res;
				o.ac = ~x[4];
			end
			ALU_ANA: begin
				o.res = a & b;
				x = a | b;
				o.ac = x[3];
			end
			default: begin
				o.res = (sel == ALU_XRA) ? (a ^ b) : (a | b);
				x = '0;
			end
		endcase
		return o;
	endfunction

	function automatic alu_out_t daa_f(input logic [7:0] a, input logic ac, input logic cy);
		alu_out_t   o;
		logic [7:0] corr;
		logic [4:0] t;
		corr = '0;
		o.cy = cy;
		if (ac || a[3:0] > 4'd9) begin
			corr[3:0] = 4'h6;
		end
		if (cy || a[7:4] > 4'd9 || (a[7:4] >= 4'd9 && a[3:0] > 4'd9)) begin
			corr[7:4] = 4'h6;
			o.cy = 1'b1;
		end
		o.res = a + corr;
		t = {1'b0, a[3:0]} + {1'b0, corr[3:0]};
		o.ac = t[4];
		return o;
	endfunction

	function automatic logic in_window(input logic [15:0] ad, input logic [16:0] lo,
			input logic [16:0] hi);
		return ({1'b0, ad} >= lo) && ({1'b0, ad} < hi);
	endfunction

endpackage

@@ hw/rtl/i8080_cpu_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8080_cpu_core
// 8080 processor core with internal byte memory and a port shift register.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. The
// request type selects a memory byte load, the execution of one instruction
// or a restart interrupt. Every request produces exactly one result: done is
// high for one cycle and pc_now, acc_now, psw_now, halted and the OUT fields
// are valid in that cycle. The receiver cannot stall; the result is simply
// shown for that cycle and a new request may be started in the same cycle.
// A load, an execute while halted, an interrupt while disabled and the
// unused request type complete without leaving the idle state. An
// instruction first fetches three bytes from the single memory port, then
// makes up to two operand reads and up to two stores on that same port. A
// taken interrupt makes two stack stores. Configuration writes over
// cfg_valid/cfg_ready are always accepted and are meant for idle periods.
// Reset clears the architectural registers but for the run flag, which it
// sets, and restores the writable window; memory contents are undefined
// until loaded.
// ----------------------------------------------------------------------------
module i8080_cpu_core
	import i8080_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] mem_address,
	input  logic [7:0]  mem_data,
	input  logic        load_last,
	input  logic [2:0]  irq_vector,
	input  logic [7:0]  in_port_data,
	output logic        done,
	output logic [15:0] pc_now,
	output logic [7:0]  acc_now,
	output logic [7:0]  psw_now,
	output logic        halted,
	output logic        out_valid,
	output logic [7:0]  out_port,
	output logic [7:0]  out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_OP   = 4'd1;
	localparam logic [3:0] ST_B1   = 4'd2;
	localparam logic [3:0] ST_B2   = 4'd3;
	localparam logic [3:0] ST_B3   = 4'd4;
	localparam logic [3:0] ST_M0   = 4'd5;
	localparam logic [3:0] ST_M1   = 4'd6;
	localparam logic [3:0] ST_M2   = 4'd7;
	localparam logic [3:0] ST_EX   = 4'd8;
	localparam logic [3:0] ST_W0   = 4'd9;
	localparam logic [3:0] ST_W1   = 4'd10;

	logic [3:0]  state_q;
	logic        done_q;

	// Architectural state.
	logic [7:0]  b_q, c_q, d_q, e_q, h_q, l_q, a_q;
	logic [15:0] sp_q, pc_q;
	logic [4:0]  fl_q;
	logic        ie_q, run_q;
	logic [15:0] sw_q;
	logic [2:0]  sa_q;
	logic [16:0] wlo_q, whi_q;

	// Instruction and operand capture.
	logic [7:0]  op_q, b1_q, b2_q, d0_q, d1_q, rdata_q, inp_q;
	logic [1:0]  wn_q;
	logic [15:0] wa0_q, wa1_q;
	logic [7:0]  wd0_q, wd1_q;
	logic        ov_q;
	logic [7:0]  oport_q, odata_q;

	// Memory with one write and one registered read port.
	logic [7:0]  mem_q [MEM_DEPTH];
	logic        mem_we;
	logic [15:0] mem_wa, mem_ra;
	logic [7:0]  mem_wd;

	logic        accept;
	logic [2:0]  mid, low;
	logic [1:0]  rpi;
	logic [15:0] imm, hl, rpv;
	logic [1:0]  nrd;
	logic [15:0] a0;

	// Results of the execute step.
	logic [7:0]  x_r [8];
	logic [15:0] n_sp, n_pc, n_sw;
	logic [4:0]  n_fl;
	logic        n_ie, n_run;
	logic [2:0]  n_sa;
	logic [1:0]  n_wn;
	logic [15:0] n_wa0, n_wa1;
	logic [7:0]  n_wd0, n_wd1;
	logic        n_ov;
	logic [7:0]  n_oport, n_odata;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign mid       = op_q[5:3];
	assign low       = op_q[2:0];
	assign rpi       = op_q[5:4];
	assign imm       = {b2_q, b1_q};
	assign hl        = {h_q, l_q};

	always_comb begin
		case (rpi)
			2'd0:    rpv = {b_q, c_q};
			2'd1:    rpv = {d_q, e_q};
			2'd2:    rpv = hl;
			default: rpv = sp_q;
		endcase
	end

	// Operand read decode: how many bytes, starting where.
	always_comb begin
		nrd = 2'd0;
		a0 = hl;
		case (op_q[7:6])
			2'd0: begin
				if (low == 3'd2) begin
					if (mid == 3'd1) begin
						nrd = 2'd1;
						a0 = {b_q, c_q};
					end else if (mid == 3'd3) begin
						nrd = 2'd1;
						a0 = {d_q, e_q};
					end else if (mid == 3'd5) begin
						nrd = 2'd2;
						a0 = imm;
					end else if (mid == 3'd7) begin
						nrd = 2'd1;
						a0 = imm;
					end
				end else if ((low == 3'd4 || low == 3'd5) && mid == 3'd6) begin
					nrd = 2'd1;
				end
			end
			2'd1: begin
				if (low == 3'd6 && op_q != OP_HLT) nrd = 2'd1;
			end
			2'd2: begin
				if (low == 3'd6) nrd = 2'd1;
			end
			default: begin
				if (low == 3'd0 || op_q == OP_XTHL ||
						(low == 3'd1 && (!mid[0] || rpi < 2'd2))) begin
					nrd = 2'd2;
					a0 = sp_q;
				end
			end
		endcase
	end

	// Execute step: one instruction's effect from the captured bytes.
	always_comb begin
		logic [7:0]  srcv, dstv, v, a;
		logic [15:0] popw, psh_val, next;
		logic [16:0] s17;
		logic        cnd, psh, szp_en;
		logic [7:0]  szp_v;
		logic [4:0]  fl;
		alu_out_t    ao;
		alu_out_t    au;
		logic [15:0] shv;

		a = a_q;
		x_r[0] = b_q; x_r[1] = c_q; x_r[2] = d_q; x_r[3] = e_q;
		x_r[4] = h_q; x_r[5] = l_q; x_r[6] = 8'h00; x_r[7] = a_q;
		srcv = (low == 3'd6) ? d0_q : x_r[low];
		dstv = (mid == 3'd6) ? d0_q : x_r[mid];
		popw = {d1_q, d0_q};
		fl = fl_q;
		case (mid[2:1])
			2'd0:    cnd = fl_q[F_Z];
			2'd1:    cnd = fl_q[F_CY];
			2'd2:    cnd = fl_q[F_P];
			default: cnd = fl_q[F_S];
		endcase
		cnd = mid[0] ? cnd : ~cnd;
		// One ALU serves both the register and the immediate forms.
		au = alu_f(mid, a, op_q[6] ? b1_q : srcv, fl_q[F_CY]);
		shv = sw_q >> (4'd8 - {1'b0, sa_q});
		next = pc_q + 16'd1;
		n_sp = sp_q; n_sw = sw_q; n_sa = sa_q; n_ie = ie_q; n_run = run_q;
		n_wn = 2'd0; n_wa0 = hl; n_wa1 = hl; n_wd0 = 8'h00; n_wd1 = 8'h00;
		n_ov = 1'b0; n_oport = 8'h00; n_odata = 8'h00;
		psh = 1'b0; psh_val = next;
		szp_en = 1'b0; szp_v = 8'h00;
		s17 = '0; v = 8'h00; ao = '0;

		case (op_q[7:6])
			2'd0: begin
				case (low)
					3'd1: begin
						if (mid[0]) begin
							s17 = {1'b0, hl} + {1'b0, rpv};
							fl[F_CY] = s17[16];
							x_r[4] = s17[15:8];
							x_r[5] = s17[7:0];
						end else begin
							next = pc_q + 16'd3;
							case (rpi)
								2'd0: begin x_r[0] = b2_q; x_r[1] = b1_q; end
								2'd1: begin x_r[2] = b2_q; x_r[3] = b1_q; end
								2'd2: begin x_r[4] = b2_q; x_r[5] = b1_q; end
								default: n_sp = imm;
							endcase
						end
					end
					3'd2: begin
						case (mid)
							3'd0: begin n_wn = 2'd1; n_wa0 = {b_q, c_q}; n_wd0 = a; end
							3'd2: begin n_wn = 2'd1; n_wa0 = {d_q, e_q}; n_wd0 = a; end
							3'd1, 3'd3: x_r[7] = d0_q;
							3'd4: begin
								next = pc_q + 16'd3;
								n_wn = 2'd2;
								n_wa0 = imm; n_wd0 = l_q;
								n_wa1 = imm + 16'd1; n_wd1 = h_q;
							end
							3'd5: begin
								next = pc_q + 16'd3;
								x_r[5] = d0_q;
								x_r[4] = d1_q;
							end
							3'd6: begin
								next = pc_q + 16'd3;
								n_wn = 2'd1; n_wa0 = imm; n_wd0 = a;
							end
							default: begin
								next = pc_q + 16'd3;
								x_r[7] = d0_q;
							end
						endcase
					end
					3'd3: begin
						s17[15:0] = rpv + (mid[0] ? 16'hFFFF : 16'd1);
						case (rpi)
							2'd0: begin x_r[0] = s17[15:8]; x_r[1] = s17[7:0]; end
							2'd1: begin x_r[2] = s17[15:8]; x_r[3] = s17[7:0]; end
							2'd2: begin x_r[4] = s17[15:8]; x_r[5] = s17[7:0]; end
							default: n_sp = s17[15:0];
						endcase
					end
					3'd4, 3'd5: begin
						v = (low == 3'd4) ? dstv + 8'd1 : dstv - 8'd1;
						if (mid == 3'd6) begin
							n_wn = 2'd1; n_wd0 = v;
						end else begin
							x_r[mid] = v;
						end
						fl[F_AC] = (low == 3'd4) ? (v[3:0] == 4'h0) : (v[3:0] != 4'hF);
						szp_en = 1'b1; szp_v = v;
					end
					3'd6: begin
						next = pc_q + 16'd2;
						if (mid == 3'd6) begin
							n_wn = 2'd1; n_wd0 = b1_q;
						end else begin
							x_r[mid] = b1_q;
						end
					end
					3'd7: begin
						case (mid)
							3'd0: begin fl[F_CY] = a[7]; x_r[7] = {a[6:0], a[7]}; end
							3'd1: begin fl[F_CY] = a[0]; x_r[7] = {a[0], a[7:1]}; end
							3'd2: begin fl[F_CY] = a[7]; x_r[7] = {a[6:0], fl_q[F_CY]}; end
							3'd3: begin fl[F_CY] = a[0]; x_r[7] = {fl_q[F_CY], a[7:1]}; end
							3'd4: begin
								ao = daa_f(a, fl_q[F_AC], fl_q[F_CY]);
								x_r[7] = ao.res;
								fl[F_AC] = ao.ac;
								fl[F_CY] = ao.cy;
								szp_en = 1'b1; szp_v = ao.res;
							end
							3'd5: x_r[7] = ~a;
							3'd6: fl[F_CY] = 1'b1;
							default: fl[F_CY] = ~fl_q[F_CY];
						endcase
					end
					default: ;
				endcase
			end
			2'd1: begin
				if (op_q == OP_HLT) begin
					n_run = 1'b0;
				end else if (mid == 3'd6) begin
					n_wn = 2'd1; n_wd0 = srcv;
				end else begin
					x_r[mid] = srcv;
				end
			end
			2'd2: begin
				fl[F_CY] = au.cy; fl[F_AC] = au.ac;
				szp_en = 1'b1; szp_v = au.res;
				if (mid != ALU_CMP) x_r[7] = au.res;
			end
			default: begin
				case (low)
					3'd0: begin
						if (cnd) begin
							next = popw;
							n_sp = sp_q + 16'd2;
						end
					end
					3'd1: begin
						if (!mid[0]) begin
							n_sp = sp_q + 16'd2;
							case (rpi)
								2'd0: begin x_r[0] = d1_q; x_r[1] = d0_q; end
								2'd1: begin x_r[2] = d1_q; x_r[3] = d0_q; end
								2'd2: begin x_r[4] = d1_q; x_r[5] = d0_q; end
								default: begin
									x_r[7] = d1_q;
									fl = {d0_q[7], d0_q[6], d0_q[4], d0_q[2], d0_q[0]};
								end
							endcase
						end else if (rpi < 2'd2) begin
							next = popw;
							n_sp = sp_q + 16'd2;
						end else if (rpi == 2'd2) begin
							next = hl;
						end else begin
							n_sp = hl;
						end
					end
					3'd2: next = cnd ? imm : pc_q + 16'd3;
					3'd3: begin
						case (mid)
							3'd0, 3'd1: next = imm;
							3'd2: begin
								next = pc_q + 16'd2;
								n_ov = 1'b1; n_oport = b1_q; n_odata = a;
								if (b1_q == 8'd2) n_sa = a[2:0];
								else if (b1_q == 8'd4) n_sw = {a, sw_q[15:8]};
							end
							3'd3: begin
								next = pc_q + 16'd2;
								x_r[7] = (b1_q == 8'd3) ? shv[7:0] : inp_q;
							end
							3'd4: begin
								n_wn = 2'd2;
								n_wa0 = sp_q; n_wd0 = l_q;
								n_wa1 = sp_q + 16'd1; n_wd1 = h_q;
								x_r[5] = d0_q; x_r[4] = d1_q;
							end
							3'd5: begin
								x_r[2] = h_q; x_r[3] = l_q;
								x_r[4] = d_q; x_r[5] = e_q;
							end
							3'd6: n_ie = 1'b0;
							default: n_ie = 1'b1;
						endcase
					end
					3'd4: begin
						next = pc_q + 16'd3;
						if (cnd) begin
							psh = 1'b1; psh_val = next; next = imm;
						end
					end
					3'd5: begin
						psh = 1'b1;
						if (mid[0]) begin
							next = pc_q + 16'd3;
							psh_val = next;
							next = imm;
						end else if (rpi == 2'd3) begin
							psh_val = {a, fl_q[F_S], fl_q[F_Z], 1'b0, fl_q[F_AC], 1'b0,
								fl_q[F_P], 1'b1, fl_q[F_CY]};
						end else begin
							psh_val = rpv;
						end
					end
					3'd6: begin
						fl[F_CY] = au.cy; fl[F_AC] = au.ac;
						szp_en = 1'b1; szp_v = au.res;
						if (mid != ALU_CMP) x_r[7] = au.res;
						next = pc_q + 16'd2;
					end
					default: begin
						psh = 1'b1;
						psh_val = next;
						next = {10'd0, mid, 3'd0};
					end
				endcase
			end
		endcase

		if (psh) begin
			n_wn = 2'd2;
			n_wa0 = sp_q - 16'd1; n_wd0 = psh_val[15:8];
			n_wa1 = sp_q - 16'd2; n_wd1 = psh_val[7:0];
			n_sp = sp_q - 16'd2;
		end
		if (szp_en) begin
			fl[F_S] = szp_v[7];
			fl[F_Z] = (szp_v == 8'h00);
			fl[F_P] = ~^szp_v;
		end
		n_fl = fl;
		n_pc = next;
	end

	// Memory port selection.
	always_comb begin
		case (state_q)
			ST_OP:   mem_ra = pc_q;
			ST_B1:   mem_ra = pc_q + 16'd1;
			ST_B2:   mem_ra = pc_q + 16'd2;
			ST_M0:   mem_ra = a0;
			ST_M1:   mem_ra = a0 + 16'd1;
			default: mem_ra = pc_q;
		endcase
		mem_we = 1'b0;
		mem_wa = mem_address;
		mem_wd = mem_data;
		if (accept && req_type == REQ_LOAD) begin
			mem_we = 1'b1;
		end else if (state_q == ST_W0) begin
			mem_we = in_window(wa0_q, wlo_q, whi_q);
			mem_wa = wa0_q;
			mem_wd = wd0_q;
		end else if (state_q == ST_W1) begin
			mem_we = in_window(wa1_q, wlo_q, whi_q);
			mem_wa = wa1_q;
			mem_wd = wd1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa[MEM_AW-1:0]] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[mem_ra[MEM_AW-1:0]];
	end

	// Window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlo_q <= WRITE_LOW_RST;
			whi_q <= WRITE_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_WRITE_LOW) wlo_q <= cfg_data;
			else whi_q <= cfg_data;
		end
	end

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			h_q <= '0; l_q <= '0; a_q <= '0;
			sp_q <= '0; pc_q <= '0; fl_q <= '0;
			ie_q <= 1'b0; run_q <= 1'b1;
			sw_q <= '0; sa_q <= '0;
			wn_q <= '0;
			ov_q <= 1'b0; oport_q <= '0; odata_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ov_q <= 1'b0; oport_q <= '0; odata_q <= '0;
						inp_q <= in_port_data;
						if (req_type == REQ_EXEC && run_q) begin
							state_q <= ST_OP;
						end else if (req_type == REQ_IRQ && ie_q) begin
							wn_q <= 2'd2;
							wa0_q <= sp_q - 16'd1; wd0_q <= pc_q[15:8];
							wa1_q <= sp_q - 16'd2; wd1_q <= pc_q[7:0];
							sp_q <= sp_q - 16'd2;
							pc_q <= {10'd0, irq_vector, 3'd0};
							ie_q <= 1'b0;
							run_q <= 1'b1;
							state_q <= ST_W0;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_OP: state_q <= ST_B1;
				ST_B1: begin
					op_q <= rdata_q;
					state_q <= ST_B2;
				end
				ST_B2: begin
					b1_q <= rdata_q;
					state_q <= ST_B3;
				end
				ST_B3: begin
					b2_q <= rdata_q;
					state_q <= (nrd == 2'd0) ? ST_EX : ST_M0;
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: begin
					d0_q <= rdata_q;
					state_q <= (nrd == 2'd2) ? ST_M2 : ST_EX;
				end
				ST_M2: begin
					d1_q <= rdata_q;
					state_q <= ST_EX;
				end
				ST_EX: begin
					b_q <= x_r[0]; c_q <= x_r[1]; d_q <= x_r[2]; e_q <= x_r[3];
					h_q <= x_r[4]; l_q <= x_r[5]; a_q <= x_r[7];
					sp_q <= n_sp; pc_q <= n_pc; fl_q <= n_fl;
					ie_q <= n_ie; run_q <= n_run;
					sw_q <= n_sw; sa_q <= n_sa;
					wn_q <= n_wn;
					wa0_q <= n_wa0; wd0_q <= n_wd0;
					wa1_q <= n_wa1; wd1_q <= n_wd1;
					ov_q <= n_ov; oport_q <= n_oport; odata_q <= n_odata;
					if (n_wn == 2'd0) begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end else begin
						state_q <= ST_W0;
					end
				end
				ST_W0: begin
					if (wn_q == 2'd2) begin
						state_q <= ST_W1;
					end else begin
						state_q <= ST_IDLE;
						done_q <= 1'b1;
					end
				end
				ST_W1: begin
					state_q <= ST_IDLE;
					done_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done      = done_q;
	assign pc_now    = pc_q;
	assign acc_now   = a_q;
	assign psw_now   = {fl_q[F_S], fl_q[F_Z], 1'b0, fl_q[F_AC], 1'b0, fl_q[F_P], 1'b1,
		fl_q[F_CY]};
	assign halted    = ~run_q;
	assign out_valid = ov_q;
	assign out_port  = oport_q;
	assign out_data  = odata_q;

	// A result is only ever shown once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// Stores from the processor never land outside the writable window.
	a_store_window: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == ST_W0 || state_q == ST_W1)) |->
			in_window(mem_wa, wlo_q, whi_q))
		else $error("store outside writable window");

	// An execute request on a running processor starts an opcode fetch.
	a_exec_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_EXEC && run_q) |=> (state_q == ST_OP))
		else $error("execute request did not start a fetch");

	// Every instruction that reaches execute returns to idle after its stores.
	a_ex_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EX) |-> ##[1:3] (state_q == ST_IDLE))
		else $error("instruction did not finish");

endmodule
